### hw/rtl/sccx_pkg.sv
// ============================================================================
// sccx_pkg: shared types and constants for the execute block
// Instruction fields, item operation codes, status codes, FSM states and the
// structs that travel between the top level and the divider.
// ============================================================================
package sccx_pkg;

    // Datapath widths
    localparam int DATA_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int REG_COUNT     = 8;
    localparam int REG_AW        = 3;
    localparam int MEM_DEPTH_DEF = 256;

    // Item operations (tuser of the input channel)
    localparam logic [1:0] OP_EXEC    = 2'd0;
    localparam logic [1:0] OP_PRELOAD = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Instruction opcodes, bits 14..9
    localparam logic [5:0] OPC_ADD   = 6'd0;
    localparam logic [5:0] OPC_SUB   = 6'd1;
    localparam logic [5:0] OPC_MUL   = 6'd2;
    localparam logic [5:0] OPC_DIV   = 6'd3;
    localparam logic [5:0] OPC_LOAD  = 6'd4;
    localparam logic [5:0] OPC_STORE = 6'd5;
    localparam logic [5:0] OPC_END   = 6'h3F;

    // Result status codes
    localparam logic [2:0] STAT_DONE    = 3'd0;
    localparam logic [2:0] STAT_END     = 3'd1;
    localparam logic [2:0] STAT_DIV0    = 3'd2;
    localparam logic [2:0] STAT_UNKNOWN = 3'd3;
    localparam logic [2:0] STAT_HALTED  = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_DIV,
        ST_RD_MEM,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [2:0]        status;
        logic              reg_write;
        logic [REG_AW-1:0] dest_reg;
        logic [DATA_W-1:0] dest_value;
        logic              mem_write;
        logic [BYTE_W-1:0] store_address;
        logic [BYTE_W-1:0] store_byte;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

### hw/rtl/sccx_ram.sv
// ============================================================================
// sccx_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module sccx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/sccx_div.sv
// ============================================================================
// sccx_div: radix-2 restoring unsigned divider
// Produces one quotient bit per cycle; done pulses once all DATA_W quotient bits are formed.
// ============================================================================
module sccx_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sccx_pkg::t_div_req i_req,
    output sccx_pkg::t_div_rsp o_rsp
);
    import sccx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   w_trial;
    logic              w_fit;

    // Shift in the next dividend bit and test against the divisor
    assign w_trial = {r_rem, r_quo[DATA_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    // Control: busy while the DATA_W quotient bits are formed, then a one-cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? DATA_W'(w_trial - {1'b0, r_dvs}) : w_trial[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### hw/rtl/single_cycle_cpu_execute.sv
// ============================================================================
// single_cycle_cpu_execute: instruction execute block with register file and
// data memory held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the item operation
// (execute, preload register, read memory byte), tdata the instruction word,
// preload index/value and readback address. Every item gives exactly one
// result on the m_axis channel: tuser is the status, tdata the write-back,
// store and readback fields.
// One item is in flight at a time. States from accept to the next accept:
// preload, halted execute or null item go straight to RESULT; readback
// passes RD_MEM; ALU, load and store pass RD_A, RD_B and EXEC (two reads of
// the one register-file RAM port, then execute); divide also waits in DIV for
// the radix-2 divider. After reset the block sweeps both RAMs to zero, one
// entry per cycle, over all MEM_DEPTH entries; tready stays low meanwhile.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block stalls only when a second result is ready
// before the first is taken. Halt is sticky until reset.
// ============================================================================
module single_cycle_cpu_execute #(
    parameter int MEM_DEPTH = sccx_pkg::MEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // instruction[15:0], preload_index[18:16], preload_value[34:19],
    // read_address[42:35], zero pad[47:43]
    input  logic [47:0] i_s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // reg_write[0], dest_reg[3:1], dest_value[19:4], mem_write[20],
    // store_address[28:21], store_byte[36:29], read_byte[44:37], zero pad[47:45]
    output logic [47:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]  o_m_axis_tuser
);
    import sccx_pkg::*;

    localparam int MEM_AW = $clog2(MEM_DEPTH);

    // Reduce an 8-bit byte address modulo MEM_DEPTH by shifted subtraction
    function automatic logic [MEM_AW-1:0] f_mem_index(input logic [BYTE_W-1:0] addr);
        logic [12:0] rem;
        rem = {5'd0, addr};
        for (int k = 4; k >= 0; k--) begin
            if (rem >= (13'(MEM_DEPTH) << k)) begin
                rem = rem - (13'(MEM_DEPTH) << k);
            end
        end
        return rem[MEM_AW-1:0];
    endfunction

    // Input unpacking
    logic [1:0]        w_in_op;
    logic [DATA_W-1:0] w_in_instr;
    logic [REG_AW-1:0] w_in_pidx;
    logic [DATA_W-1:0] w_in_pval;
    logic [BYTE_W-1:0] w_in_raddr;

    assign w_in_op    = i_s_axis_tuser;
    assign w_in_instr = i_s_axis_tdata[15:0];
    assign w_in_pidx  = i_s_axis_tdata[18:16];
    assign w_in_pval  = i_s_axis_tdata[34:19];
    assign w_in_raddr = i_s_axis_tdata[42:35];

    // State
    t_state            r_state, n_state;
    logic [MEM_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic              r_halted, n_halted;
    logic              r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_instr, n_instr;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    t_result           r_res, n_res;
    t_result           r_m_data, n_m_data;

    // RAM ports
    logic              w_reg_we;
    logic [REG_AW-1:0] w_reg_waddr;
    logic [DATA_W-1:0] w_reg_wdata;
    logic [REG_AW-1:0] w_reg_raddr;
    logic [DATA_W-1:0] w_reg_rdata;
    logic              w_mem_we;
    logic [MEM_AW-1:0] w_mem_waddr;
    logic [BYTE_W-1:0] w_mem_wdata;
    logic [MEM_AW-1:0] w_mem_raddr;
    logic [BYTE_W-1:0] w_mem_rdata;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    logic [5:0]        w_opc;
    logic [REG_AW-1:0] w_dest;
    logic [DATA_W-1:0] w_alu;

    assign w_opc  = r_instr[14:9];
    assign w_dest = r_instr[8:6];

    // Arithmetic on the registered operands, low 16 bits kept
    always_comb begin
        case (w_opc)
            OPC_ADD: w_alu = r_a + r_b;
            OPC_SUB: w_alu = r_a - r_b;
            OPC_MUL: w_alu = DATA_W'(r_a * r_b);
            default: w_alu = r_a;
        endcase
    end

    sccx_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (w_reg_we),
        .i_waddr (w_reg_waddr),
        .i_wdata (w_reg_wdata),
        .i_raddr (w_reg_raddr),
        .o_rdata (w_reg_rdata)
    );

    sccx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    sccx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Next state, RAM accesses and result assembly
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_halted  = r_halted;
        n_instr   = r_instr;
        n_a       = r_a;
        n_b       = r_b;
        n_res     = r_res;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;

        w_reg_we    = 1'b0;
        w_reg_waddr = w_dest;
        w_reg_wdata = w_alu;
        w_reg_raddr = w_in_instr[5:3];
        w_mem_we    = 1'b0;
        w_mem_waddr = f_mem_index(r_a[BYTE_W-1:0]);
        w_mem_wdata = r_b[BYTE_W-1:0];
        w_mem_raddr = f_mem_index(w_in_raddr);

        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_a;
        w_div_req.divisor  = r_b;

        o_s_axis_tready = 1'b0;

        case (r_state)
            // Zero both RAMs, one entry per cycle
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_cnt;
                w_mem_wdata = '0;
                w_reg_we    = (r_clr_cnt < MEM_AW'(REG_COUNT));
                w_reg_waddr = r_clr_cnt[REG_AW-1:0];
                w_reg_wdata = '0;
                if (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            // Take one item; first register read goes out with the transfer
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_instr = w_in_instr;
                    n_res   = '0;
                    case (w_in_op)
                        OP_EXEC: begin
                            if (r_halted) begin
                                n_res.status = STAT_HALTED;
                                n_state      = ST_RESULT;
                            end else begin
                                n_state = ST_RD_A;
                            end
                        end
                        OP_PRELOAD: begin
                            w_reg_we         = 1'b1;
                            w_reg_waddr      = w_in_pidx;
                            w_reg_wdata      = w_in_pval;
                            n_res.reg_write  = 1'b1;
                            n_res.dest_reg   = w_in_pidx;
                            n_res.dest_value = w_in_pval;
                            n_state          = ST_RESULT;
                        end
                        OP_READ: begin
                            n_state = ST_RD_MEM;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            // Capture first source, read second
            ST_RD_A: begin
                n_a         = w_reg_rdata;
                w_reg_raddr = r_instr[2:0];
                n_state     = ST_RD_B;
            end
            ST_RD_B: begin
                n_b     = w_reg_rdata;
                n_state = ST_EXEC;
            end
            // Execute and write back
            ST_EXEC: begin
                n_state = ST_RESULT;
                case (w_opc)
                    OPC_ADD, OPC_SUB, OPC_MUL, OPC_LOAD: begin
                        w_reg_we         = 1'b1;
                        n_res.reg_write  = 1'b1;
                        n_res.dest_reg   = w_dest;
                        n_res.dest_value = w_alu;
                    end
                    OPC_DIV: begin
                        if (r_b == '0) begin
                            n_halted     = 1'b1;
                            n_res.status = STAT_DIV0;
                        end else begin
                            w_div_req.start = 1'b1;
                            n_state         = ST_DIV;
                        end
                    end
                    OPC_STORE: begin
                        w_mem_we            = 1'b1;
                        n_res.mem_write     = 1'b1;
                        n_res.store_address = r_a[BYTE_W-1:0];
                        n_res.store_byte    = r_b[BYTE_W-1:0];
                    end
                    OPC_END: begin
                        n_halted     = 1'b1;
                        n_res.status = STAT_END;
                    end
                    default: begin
                        n_halted     = 1'b1;
                        n_res.status = STAT_UNKNOWN;
                    end
                endcase
            end
            // Wait for the quotient, then write it back
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    w_reg_we         = 1'b1;
                    w_reg_wdata      = w_div_rsp.quotient;
                    n_res.reg_write  = 1'b1;
                    n_res.dest_reg   = w_dest;
                    n_res.dest_value = w_div_rsp.quotient;
                    n_state          = ST_RESULT;
                end
            end
            ST_RD_MEM: begin
                n_res.read_byte = w_mem_rdata;
                n_state         = ST_RESULT;
            end
            // Hand the result to the output register once it is free
            ST_RESULT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_halted  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_halted  <= n_halted;
            r_m_valid <= n_m_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_instr  <= n_instr;
        r_a      <= n_a;
        r_b      <= n_b;
        r_res    <= n_res;
        r_m_data <= n_m_data;
    end

    // Output packing
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m_data.status;
    assign o_m_axis_tdata  = {3'b000, r_m_data.read_byte, r_m_data.store_byte,
                              r_m_data.store_address, r_m_data.mem_write,
                              r_m_data.dest_value, r_m_data.dest_reg,
                              r_m_data.reg_write};

    // Halt is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped without reset");

    // Divider completes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider done outside divide wait");

    // A halted execute reports no register or memory write
    a_halted_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_data.status == STAT_HALTED))
            |-> (!r_m_data.reg_write && !r_m_data.mem_write))
        else $error("write reported on an ignored instruction");

    // Register and memory writes never coincide outside the clearing sweep
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> !(w_reg_we && w_mem_we))
        else $error("register and memory written in one cycle");

endmodule
